[sv/isbn10_format_checker_defines.svh]
// Assertion macros for the ISBN-10 format checker.
// Needs clk and rst_n in the scope where a macro is used.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ISBN10_FORMAT_CHECKER_DEFINES_SVH
`define ISBN10_FORMAT_CHECKER_DEFINES_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge out of reset
`define ISBN_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define ISBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ISBN_ASSERT_ALWAYS(lbl, cond, msg)
`define ISBN_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/isbn10fc_pkg.sv]
// Shared types, constants and the mod-11 reduction for the ISBN-10 checker.
// No dependencies.
package isbn10fc_pkg;

    // default string length bound: longer than MAX_LEN-1 characters is rejected
    localparam int         DEF_MAX_LEN = 32;

    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_X      = 8'h58;

    localparam logic [4:0] FIRST_HY_MIN = 5'd1;
    localparam logic [4:0] FIRST_HY_MAX = 5'd5;
    localparam logic [4:0] GAP_MIN      = 5'd2;
    localparam logic [4:0] GAP2_MAX     = 5'd8;
    localparam logic [4:0] GAP3_MAX     = 5'd7;

    localparam logic [4:0] POS_SAT      = 5'd31;
    localparam logic [2:0] HY_SAT       = 3'd4;
    localparam logic [2:0] HY_NEEDED    = 3'd3;
    localparam logic [3:0] SYM_MAX      = 4'd10;
    localparam logic [3:0] SYM_SAT      = 4'd15;
    localparam logic [3:0] WEIGHT_START = 4'd10;
    localparam logic [3:0] X_VALUE      = 4'd10;

    typedef struct packed {
        logic [4:0] char_position;
        logic [2:0] hyphen_count;
        logic [4:0] previous_hyphen_position;
        logic       previous_was_hyphen;
        logic       syntax_error;
        logic [3:0] digit_weight;
        logic [3:0] symbol_count;
        logic [3:0] sum_mod_eleven;
    } state_t;

    localparam state_t STATE_RESET = '{
        char_position:            5'd0,
        hyphen_count:             3'd0,
        previous_hyphen_position: 5'd0,
        previous_was_hyphen:      1'b0,
        syntax_error:             1'b0,
        digit_weight:             WEIGHT_START,
        symbol_count:             4'd0,
        sum_mod_eleven:           4'd0
    };

    typedef struct packed {
        logic syntax_ok;
        logic checksum_ok;
        logic valid_res;
    } result_t;

    // reduce 0..127 mod 11 by conditional subtracts of 88, 44, 22, 11
    function automatic logic [3:0] mod11(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (r >= 7'd88) r = r - 7'd88;
        if (r >= 7'd44) r = r - 7'd44;
        if (r >= 7'd22) r = r - 7'd22;
        if (r >= 7'd11) r = r - 7'd11;
        return r[3:0];
    endfunction

endpackage

[sv/isbn10fc_step.sv]
// One character step of the ISBN-10 checker: next state and end-of-string result.
// Depends on isbn10fc_pkg.
module isbn10fc_step
    import isbn10fc_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  state_t     st,
    input  logic [7:0] ch,
    input  logic       last,
    output state_t     st_next,
    output result_t    res
);

    // strings longer than MAX_LEN-1 characters are rejected
    localparam logic [6:0] LEN_LIMIT = 7'(MAX_LEN - 1);

    logic       is_digit;
    logic       is_hy;
    logic       is_x;
    logic       err;
    logic [4:0] gap;
    logic [6:0] prod;
    logic [6:0] sum_wide;
    logic       syn;
    state_t     upd;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_hy    = (ch == CH_HYPHEN);
    assign is_x     = (ch == CH_X);
    assign gap      = st.char_position - st.previous_hyphen_position;
    // '0' is 0x30, so the low nibble is the digit value
    assign prod     = 7'(ch[3:0]) * 7'(st.digit_weight);

    always_comb
    begin
        upd      = st;
        err      = st.syntax_error;
        sum_wide = 7'd0;

        if ((7'({2'b00, st.char_position}) + 7'd1) > LEN_LIMIT) err = 1'b1;
        if (!(is_digit || is_hy || is_x)) err = 1'b1;

        if (is_hy)
        begin
            if (st.previous_was_hyphen) err = 1'b1;
            case (st.hyphen_count)
                3'd0:
                begin
                    if (st.char_position < FIRST_HY_MIN || st.char_position > FIRST_HY_MAX)
                        err = 1'b1;
                end
                3'd1:
                begin
                    if (gap < GAP_MIN || gap > GAP2_MAX) err = 1'b1;
                end
                3'd2:
                begin
                    if (gap < GAP_MIN || gap > GAP3_MAX) err = 1'b1;
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
            if (st.hyphen_count < HY_SAT) upd.hyphen_count = st.hyphen_count + 3'd1;
            upd.previous_hyphen_position = st.char_position;
            upd.previous_was_hyphen      = 1'b1;
        end
        else
        begin
            if (st.symbol_count >= SYM_MAX) err = 1'b1;
            if (st.symbol_count < SYM_SAT) upd.symbol_count = st.symbol_count + 4'd1;
            if (is_digit)
            begin
                sum_wide = 7'({3'b000, st.sum_mod_eleven}) + prod;
                upd.sum_mod_eleven = mod11(sum_wide);
                if (st.digit_weight != 4'd0) upd.digit_weight = st.digit_weight - 4'd1;
            end
            else if (is_x)
            begin
                sum_wide = 7'({3'b000, st.sum_mod_eleven}) + 7'({3'b000, X_VALUE});
                upd.sum_mod_eleven = mod11(sum_wide);
            end
            upd.previous_was_hyphen = 1'b0;
        end

        if (st.char_position < POS_SAT) upd.char_position = st.char_position + 5'd1;
        upd.syntax_error = err;

        syn = !err && (upd.hyphen_count == HY_NEEDED) && !is_hy
              && ((st.char_position - upd.previous_hyphen_position) == 5'd1);
        res.syntax_ok   = syn;
        res.checksum_ok = syn && (upd.sum_mod_eleven == 4'd0);
        res.valid_res   = syn && (upd.sum_mod_eleven == 4'd0);

        // a finished string leaves the checker ready for the next one
        st_next = last ? STATE_RESET : upd;
    end

endmodule

[sv/isbn10_format_checker.sv]
// ISBN-10 format checker: one character beat in per cycle while in_stall is low, one
// result beat per string. Each accepted character is held in the input register; the
// last one leaves it only once the result register has room, and its result is then
// registered there. The state update between the two registers is combinational.
// Reset (rst_n low, async) empties both registers and returns the string state to start.
`include "isbn10_format_checker_defines.svh"

module isbn10_format_checker
    import isbn10fc_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    // character channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       last,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       syntax_ok,
    output logic       checksum_ok,
    output logic       valid_res
);

    // input register: one character beat
    logic       s1_valid_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_last_reg;

    // string state, updated as each character leaves the input register
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;

    // result register
    logic       out_valid_reg;
    result_t    res_reg;

    logic       out_free;   // result register can take a beat this cycle
    logic       s1_adv;     // input register character is consumed this cycle
    logic       in_take;

    isbn10fc_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .st      (state_reg),
        .ch      (s1_ch_reg),
        .last    (s1_last_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Only the last character needs room in the result register; the others move on
    // freely, so a waiting result holds up only the last character of the next string.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_ch_reg   <= ch;
            s1_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (s1_adv)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_adv && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign syntax_ok   = res_reg.syntax_ok;
    assign checksum_ok = res_reg.checksum_ok;
    assign valid_res   = res_reg.valid_res;

    // stall toward the source only while a last character waits for the result slot
    `ISBN_ASSERT_ALWAYS(a_stall_needs_last,
        !in_stall || (s1_valid_reg && s1_last_reg),
        "stall without a waiting last character")
    `ISBN_ASSERT_NEXT(a_last_gives_result,
        s1_adv && s1_last_reg,
        out_valid_reg && state_reg == STATE_RESET,
        "last character did not give a result and restart")
    `ISBN_ASSERT_ALWAYS(a_sum_range,
        state_reg.sum_mod_eleven < 4'd11 && state_reg.digit_weight <= WEIGHT_START,
        "checksum state out of range")
    `ISBN_ASSERT_ALWAYS(a_hyphen_order,
        state_reg.previous_hyphen_position <= state_reg.char_position,
        "hyphen position ahead of character position")
    `ISBN_ASSERT_ALWAYS(a_result_consistent,
        !out_valid_reg || ((!res_reg.checksum_ok || res_reg.syntax_ok)
        && res_reg.valid_res == res_reg.checksum_ok),
        "inconsistent result flags")

endmodule

[tb/isbn10_format_checker_tb.sv]
// Self-checking testbench for isbn10_format_checker: streams ISBN-10 strings one
// character beat at a time and predicts each string's verdict beat independently.
// Depends on isbn10fc_pkg (character codes, rule limits, result_t) and the RTL.
module isbn10_format_checker_tb;
    import isbn10fc_pkg::*;

    localparam int ISBN_MOD    = 11;
    localparam int RUN_LIMIT   = 400000;  // cycles before the run is declared hung
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int TAIL_CYCLES = 10;      // idle wait after the last result before the final check
    localparam int PHASE_CHARS = 170;

    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
    } char_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] ch = 8'd0;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       syntax_ok;
    logic       checksum_ok;
    logic       valid_res;

    char_beat_t chars_to_send[$];
    result_t    verdicts_due[$];
    int         chars_queued = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_left = 0;
    logic       hold_kick = 1'b0;
    logic       hold_seen = 1'b0;

    // predictor's copy of the per-string state
    logic [4:0] pos_q = 5'd0;
    logic [2:0] hy_q = 3'd0;
    logic [4:0] last_hy_q = 5'd0;
    logic       prev_hy_q = 1'b0;
    logic       bad_q = 1'b0;
    logic [3:0] wt_q = WEIGHT_START;
    logic [3:0] sym_q = 4'd0;
    logic [3:0] sum_q = 4'd0;

    isbn10_format_checker uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .syntax_ok  (syntax_ok),
        .checksum_ok(checksum_ok),
        .valid_res  (valid_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // Advance the string state by one accepted character; on the last one,
    // queue the verdict and start over.
    task automatic score_char(input logic [7:0] c, input logic fin);
        int      here;
        int      gap;
        logic    is_dig;
        logic    is_hy;
        logic    is_x;
        logic    syn;
        result_t v;
        here   = pos_q;
        gap    = here - int'(last_hy_q);
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        is_hy  = (c == CH_HYPHEN);
        is_x   = (c == CH_X);
        if (here + 1 > DEF_MAX_LEN - 1)
            bad_q = 1'b1;
        if (!(is_dig || is_hy || is_x))
            bad_q = 1'b1;
        if (is_hy)
        begin
            if (prev_hy_q)
                bad_q = 1'b1;
            case (hy_q)
                3'd0: if (here < int'(FIRST_HY_MIN) || here > int'(FIRST_HY_MAX)) bad_q = 1'b1;
                3'd1: if (gap < int'(GAP_MIN) || gap > int'(GAP2_MAX)) bad_q = 1'b1;
                3'd2: if (gap < int'(GAP_MIN) || gap > int'(GAP3_MAX)) bad_q = 1'b1;
                default: bad_q = 1'b1;
            endcase
            if (hy_q < HY_SAT)
                hy_q = hy_q + 3'd1;
            last_hy_q = 5'(here);
            prev_hy_q = 1'b1;
        end
        else
        begin
            if (sym_q >= SYM_MAX)
                bad_q = 1'b1;
            if (sym_q < SYM_SAT)
                sym_q = sym_q + 4'd1;
            if (is_dig)
            begin
                sum_q = 4'((int'(sum_q) + int'(c - CH_ZERO) * int'(wt_q)) % ISBN_MOD);
                if (wt_q > 4'd0)
                    wt_q = wt_q - 4'd1;
            end
            else if (is_x)
                sum_q = 4'((int'(sum_q) + int'(X_VALUE)) % ISBN_MOD);
            prev_hy_q = 1'b0;
        end
        if (pos_q < POS_SAT)
            pos_q = pos_q + 5'd1;
        if (fin)
        begin
            syn = !bad_q && (hy_q == HY_NEEDED) && !is_hy && (here - int'(last_hy_q) == 1);
            v.syntax_ok   = syn;
            v.checksum_ok = syn && (sum_q == 4'd0);
            v.valid_res   = v.checksum_ok;
            verdicts_due.push_back(v);
            pos_q     = 5'd0;
            hy_q      = 3'd0;
            last_hy_q = 5'd0;
            prev_hy_q = 1'b0;
            bad_q     = 1'b0;
            wt_q      = WEIGHT_START;
            sym_q     = 4'd0;
            sum_q     = 4'd0;
        end
    endtask

    task automatic push_beat(input logic [7:0] c, input logic fin);
        char_beat_t b;
        b.code    = c;
        b.is_last = fin;
        chars_to_send.push_back(b);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], i == s.len() - 1);
    endtask

    // Mostly well-formed hyphenated numbers with a correct check digit; a share get one
    // defect (bad byte, extra hyphen or X, dropped character, new last digit, long tail).
    task automatic queue_isbn();
        logic [7:0] body[$];
        int g1;
        int g2;
        int g3;
        int wsum;
        int wt;
        int d;
        int pick;
        int at;
        g1   = $urandom_range(5, 1);
        g3   = $urandom_range((8 - g1 < 6) ? 8 - g1 : 6, 1);
        g2   = 9 - g1 - g3;
        wsum = 0;
        wt   = 10;
        for (int i = 0; i < 9; i++)
        begin
            d = $urandom_range(9, 0);
            wsum += d * wt;
            wt--;
            body.push_back(CH_ZERO + 8'(d));
            if (i == g1 - 1 || i == g1 + g2 - 1 || i == 8)
                body.push_back(CH_HYPHEN);
        end
        d = (ISBN_MOD - wsum % ISBN_MOD) % ISBN_MOD;
        body.push_back((d == 10) ? CH_X : CH_ZERO + 8'(d));
        pick = $urandom_range(99, 0);
        at   = $urandom_range(body.size() - 1, 0);
        if (pick < 60)
            ;
        else if (pick < 68)
            body[at] = 8'($urandom);
        else if (pick < 74)
            body.insert(at, CH_HYPHEN);
        else if (pick < 80)
            body.delete(at);
        else if (pick < 86)
            body[body.size() - 1] = CH_ZERO + 8'($urandom_range(9, 0));
        else if (pick < 92)
            repeat ($urandom_range(25, 1))
                body.push_back(CH_ZERO + 8'($urandom_range(9, 0)));
        else
            body.insert(at, CH_X);
        for (int i = 0; i < body.size(); i++)
            push_beat(body[i], i == body.size() - 1);
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(40, 1);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3, 0))
                0: push_beat(CH_ZERO + 8'($urandom_range(9, 0)), i == n - 1);
                1: push_beat(CH_HYPHEN, i == n - 1);
                2: push_beat(CH_X, i == n - 1);
                default: push_beat(8'($urandom), i == n - 1);
            endcase
        end
    endtask

    task automatic wait_idle();
        while (chars_to_send.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // Character driver: a beat moves when in_valid is high and in_stall low.
    // A stalled beat is held as is; a new one is offered unless the sender idles.
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        logic       took;
        char_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch       <= 8'd0;
            last     <= 1'b0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
                score_char(ch, last);
            if (in_valid && !took)
                ;
            else if (chars_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                nxt = chars_to_send.pop_front();
                in_valid <= 1'b1;
                ch       <= nxt.code;
                last     <= nxt.is_last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Verdict monitor: compares each accepted result beat with the oldest
    // prediction, then picks the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin : check_verdicts
        result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch("result beat with no string pending");
                else
                begin
                    want = verdicts_due.pop_front();
                    if (syntax_ok !== want.syntax_ok)
                        report_mismatch($sformatf("syntax_ok %b, want %b",
                                                  syntax_ok, want.syntax_ok));
                    if (checksum_ok !== want.checksum_ok)
                        report_mismatch($sformatf("checksum_ok %b, want %b",
                                                  checksum_ok, want.checksum_ok));
                    if (valid_res !== want.valid_res)
                        report_mismatch($sformatf("valid_res %b, want %b",
                                                  valid_res, want.valid_res));
                end
            end
            if (hold_left != 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // long hold-off on the result side, started by a toggle of hold_kick
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: good number with 'X' check, byte extremes, lone digit,
        // adjacent hyphens, string ending on a hyphen
        push_text("0-8044-2957-X");
        push_beat(8'hFF, 1'b1);
        push_beat(8'h00, 1'b1);
        push_text("5");
        push_text("--");
        push_text("7-");
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
                1: begin send_idle_pct <= 84; stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  stall_pct <= 84; end
                default: begin send_idle_pct <= 19; stall_pct <= 19; end
            endcase
            target = chars_queued + PHASE_CHARS;
            while (chars_queued < target)
            begin
                if ($urandom_range(99, 0) < 85)
                    queue_isbn();
                else
                    queue_noise();
            end
            wait_idle();
        end

        // receiver holds off while the sender keeps offering beats
        send_idle_pct <= 0;
        stall_pct     <= 0;
        hold_kick     <= ~hold_kick;
        repeat (8) queue_isbn();
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
